// ----- src/tmci_pkg.sv -----
package tmci_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;

    // stream field placement
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 64;

    // register map
    localparam logic REG_ROW_COUNT = 1'b0;

    // func codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        K_LOAD  = 2'd0,
        K_QUERY = 2'd1,
        K_DROP  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [DATA_W-1:0] t;
        logic [DATA_W-1:0] th;
        logic [DATA_W-1:0] m;
    } t_row;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  idx;
        t_row              row;
    } t_item;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

endpackage

// ----- src/thrust_mass_curve_interpolator_unit.sv -----
// Motor curve interpolator: holds a table of time / thrust / propellant-mass rows
// and answers queries by piecewise linear interpolation.
// Input stream (s_axis): tuser = func (0 load row, 1 query). A load writes one row
// and gives no result; a query gives one result transaction on m_axis.
// Output stream (m_axis): tdata = thrust Q20.12 (low 32), propellant mass Q16.16.
// APB port: register 0 at byte address 0 is row_count (7 bits), rows in use.
// Only write it while the block is idle.
// Sequence: a load is written to the table from the back end's idle state. A query
// on an empty table goes straight to the output register; else it checks the
// first row, then the last row, and when it falls inside scans up to
// TABLE_ROWS-1 rows from row 1; an interpolated result then passes through the
// multiply and the two 32-step dividers.
// The row scan through the single-read-port table memory and the bit-serial
// dividers set the time that a query takes.
// Throughput: the back end works on one transaction at a time and takes the next
// one the cycle after the previous result is registered.
// A two-entry queue sits between the input side and the back end, and the
// output register lets the back end start the next transaction while a
// result waits on a stalled receiver.
// Reset clears row_count, the queue and the output valid; table contents
// are undefined until loaded. No clearing pass is run.
module thrust_mass_curve_interpolator_unit #(
    parameter int TABLE_ROWS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // s_axis
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // [5:0] row_index, [37:6] time_value, [69:38] row_thrust,
    // [101:70] row_mass, [103:102] zero
    input  logic [103:0]  i_s_axis_tdata,
    // [0] func
    input  logic          i_s_axis_tuser,
    // m_axis
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // [31:0] thrust, [63:32] propellant_mass
    output logic [63:0]   o_m_axis_tdata,
    // APB
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import tmci_pkg::*;

    logic [CNT_W-1:0]  r_row_count;
    t_row              w_row;
    t_qhead            w_head;
    logic              w_pop;
    logic [DATA_W-1:0] w_thrust;
    logic [DATA_W-1:0] w_mass;

    // config register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROW_COUNT) ? {25'b0, r_row_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ROW_COUNT)) begin
            r_row_count <= pwdata[CNT_W-1:0];
        end
    end

    assign w_row.t  = i_s_axis_tdata[37:6];
    assign w_row.th = i_s_axis_tdata[69:38];
    assign w_row.m  = i_s_axis_tdata[101:70];

    tmci_front #(
        .TABLE_ROWS (TABLE_ROWS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_func  (i_s_axis_tuser),
        .i_idx   (i_s_axis_tdata[5:0]),
        .i_row   (w_row),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    tmci_back #(
        .TABLE_ROWS (TABLE_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_row_count (r_row_count),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_thrust    (w_thrust),
        .o_mass      (w_mass)
    );

    assign o_m_axis_tdata = {w_mass, w_thrust};

endmodule

// ----- src/tmci_front.sv -----
module tmci_front #(
    parameter int TABLE_ROWS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_func,
    input  logic [tmci_pkg::IDX_W-1:0]        i_idx,
    input  tmci_pkg::t_row                    i_row,
    output tmci_pkg::t_qhead                  o_head,
    input  logic                              i_pop
);
    import tmci_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push;
    logic       w_pop;

    // classify: loads outside the table are marked as drops here
    always_comb begin
        w_item.idx = i_idx;
        w_item.row = i_row;
        if (i_func == FUNC_QUERY) begin
            w_item.kind = K_QUERY;
        end else if ({26'b0, i_idx} < 32'(TABLE_ROWS)) begin
            w_item.kind = K_LOAD;
        end else begin
            w_item.kind = K_DROP;
        end
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- src/tmci_div.sv -----
module tmci_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [2*tmci_pkg::DATA_W-1:0]    i_dividend,
    input  logic [tmci_pkg::DATA_W-1:0]      i_divisor,
    output logic                             o_done,
    output logic [tmci_pkg::DATA_W-1:0]      o_quot
);
    import tmci_pkg::*;

    localparam int CW = $clog2(DATA_W);

    // restoring divider, one quotient bit per cycle; dividend < divisor * 2^32
    logic                          r_busy;
    logic                          r_done;
    logic [CW-1:0]                 r_cnt;
    logic [DATA_W-1:0]             r_rem;
    logic [DATA_W-1:0]             r_lo;
    logic [DATA_W-1:0]             r_q;
    logic [DATA_W-1:0]             r_div;
    logic [DATA_W:0]               w_trial;
    logic [DATA_W:0]               w_diff;
    logic                          w_bit;

    assign w_trial = {r_rem, r_lo[DATA_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_bit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[2*DATA_W-1:DATA_W];
            r_lo  <= i_dividend[DATA_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_bit ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
            r_lo  <= {r_lo[DATA_W-2:0], 1'b0};
            r_q   <= {r_q[DATA_W-2:0], w_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- src/tmci_back.sv -----
module tmci_back #(
    parameter int TABLE_ROWS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tmci_pkg::t_qhead                  i_head,
    output logic                              o_pop,
    input  logic [tmci_pkg::CNT_W-1:0]        i_row_count,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [tmci_pkg::DATA_W-1:0]       o_thrust,
    output logic [tmci_pkg::DATA_W-1:0]       o_mass
);
    import tmci_pkg::*;

    localparam int AW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int NW = $clog2(TABLE_ROWS + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_ROW0   = 8'b0000_0010,
        S_LAST   = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_DSTART = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_PUSH   = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    t_row                r_mem [TABLE_ROWS];
    t_row                r_rd;
    t_row                r_prev, n_prev;
    logic [AW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_last, n_last;
    logic [DATA_W-1:0]   r_t, n_t;
    logic [DATA_W-1:0]   r_res_th, n_res_th;
    logic [DATA_W-1:0]   r_res_m, n_res_m;
    logic [DATA_W-1:0]   r_num, n_num;
    logic [DATA_W-1:0]   r_den, n_den;
    logic [DATA_W-1:0]   r_dth, n_dth;
    logic [DATA_W-1:0]   r_dm, n_dm;
    logic [DATA_W-1:0]   r_v0th, n_v0th;
    logic [DATA_W-1:0]   r_v0m, n_v0m;
    logic                r_neg_th, n_neg_th;
    logic                r_neg_m, n_neg_m;
    logic [2*DATA_W-1:0] r_pth;
    logic [2*DATA_W-1:0] r_pm;
    logic                r_ov;
    logic [DATA_W-1:0]   r_oth;
    logic [DATA_W-1:0]   r_om;
    logic [AW-1:0]       w_raddr;
    logic                w_we;
    logic [NW-1:0]       w_n;
    logic                w_out_free;
    logic                w_div_start;
    logic                w_done_th, w_done_m;
    logic [DATA_W-1:0]   w_q_th, w_q_m;

    // effective row count, clipped to the table depth
    always_comb begin
        if ({25'b0, i_row_count} > 32'(TABLE_ROWS)) begin
            w_n = NW'(TABLE_ROWS);
        end else begin
            w_n = NW'(i_row_count);
        end
    end

    assign w_out_free  = !r_ov || i_ready;
    assign w_we        = (r_state == S_IDLE) && i_head.valid && (i_head.item.kind == K_LOAD);
    assign o_pop       = (r_state == S_IDLE) && i_head.valid;
    assign w_div_start = (r_state == S_DSTART);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[AW'(i_head.item.idx)] <= i_head.item.row;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_comb begin
        n_state  = r_state;
        n_prev   = r_prev;
        n_idx    = r_idx;
        n_last   = r_last;
        n_t      = r_t;
        n_res_th = r_res_th;
        n_res_m  = r_res_m;
        n_num    = r_num;
        n_den    = r_den;
        n_dth    = r_dth;
        n_dm     = r_dm;
        n_v0th   = r_v0th;
        n_v0m    = r_v0m;
        n_neg_th = r_neg_th;
        n_neg_m  = r_neg_m;
        w_raddr  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    case (i_head.item.kind)
                        K_QUERY: begin
                            n_t = i_head.item.row.t;
                            if (w_n == '0) begin
                                n_res_th = '0;
                                n_res_m  = '0;
                                n_state  = S_PUSH;
                            end else begin
                                n_last  = AW'(w_n - NW'(1));
                                n_state = S_ROW0;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ROW0: begin
                if (r_t <= r_rd.t) begin
                    n_res_th = r_rd.th;
                    n_res_m  = r_rd.m;
                    n_state  = S_PUSH;
                end else begin
                    n_prev  = r_rd;
                    w_raddr = r_last;
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (r_t >= r_rd.t) begin
                    n_res_th = '0;
                    n_res_m  = r_rd.m;
                    n_state  = S_PUSH;
                end else begin
                    w_raddr = AW'(1);
                    n_idx   = AW'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_t == r_rd.t) begin
                    n_res_th = r_rd.th;
                    n_res_m  = r_rd.m;
                    n_state  = S_PUSH;
                end else if (r_t > r_prev.t && r_t < r_rd.t) begin
                    n_num    = r_t - r_prev.t;
                    n_den    = r_rd.t - r_prev.t;
                    n_v0th   = r_prev.th;
                    n_v0m    = r_prev.m;
                    n_neg_th = (r_rd.th < r_prev.th);
                    n_neg_m  = (r_rd.m < r_prev.m);
                    n_dth    = n_neg_th ? (r_prev.th - r_rd.th) : (r_rd.th - r_prev.th);
                    n_dm     = n_neg_m ? (r_prev.m - r_rd.m) : (r_rd.m - r_prev.m);
                    n_state  = S_MUL;
                end else if (r_idx == r_last) begin
                    // unordered times, no bracket
                    n_res_th = '0;
                    n_res_m  = '0;
                    n_state  = S_PUSH;
                end else begin
                    n_prev  = r_rd;
                    n_idx   = AW'(r_idx + AW'(1));
                    w_raddr = n_idx;
                end
            end
            S_MUL: begin
                n_state = S_DSTART;
            end
            S_DSTART: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_done_th && w_done_m) begin
                    n_res_th = r_neg_th ? (r_v0th - w_q_th) : (r_v0th + w_q_th);
                    n_res_m  = r_neg_m ? (r_v0m - w_q_m) : (r_v0m + w_q_m);
                    n_state  = S_PUSH;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prev   <= n_prev;
        r_idx    <= n_idx;
        r_last   <= n_last;
        r_t      <= n_t;
        r_res_th <= n_res_th;
        r_res_m  <= n_res_m;
        r_num    <= n_num;
        r_den    <= n_den;
        r_dth    <= n_dth;
        r_dm     <= n_dm;
        r_v0th   <= n_v0th;
        r_v0m    <= n_v0m;
        r_neg_th <= n_neg_th;
        r_neg_m  <= n_neg_m;
        if (r_state == S_MUL) begin
            r_pth <= r_num * r_dth;
            r_pm  <= r_num * r_dm;
        end
        if (r_state == S_PUSH && w_out_free) begin
            r_oth <= r_res_th;
            r_om  <= r_res_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PUSH && w_out_free) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    tmci_div u_div_th (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_pth),
        .i_divisor  (r_den),
        .o_done     (w_done_th),
        .o_quot     (w_q_th)
    );

    tmci_div u_div_m (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_pm),
        .i_divisor  (r_den),
        .o_done     (w_done_m),
        .o_quot     (w_q_m)
    );

    assign o_valid  = r_ov;
    assign o_thrust = r_oth;
    assign o_mass   = r_om;

endmodule

// ----- src/tmci_checker.sv -----
module tmci_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    input  logic [63:0]   o_m_axis_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    input  logic [31:0]   prdata,
    input  logic          pready
);
    import tmci_pkg::*;

    // result channel is empty straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result dropped or changed under stall");

    // row_count reads back what was written
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && paddr[2] == REG_ROW_COUNT
        |=> paddr[2] != REG_ROW_COUNT || prdata[CNT_W-1:0] == $past(pwdata[CNT_W-1:0]))
        else $error("row_count readback mismatch");

    // unused register bits read as zero
    a_cfg_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready && prdata[31:CNT_W] == '0)
        else $error("prdata upper bits set or pready low");

endmodule

bind thrust_mass_curve_interpolator_unit tmci_checker u_tmci_checker (.*);
